>>> rtl/core/msp_pkg.sv
package msp_pkg;

	// Default sizes of the block.
	localparam int MAX_N_DEF      = 1024;
	localparam int VALUE_BITS_DEF = 16;

	// Fixed field widths.
	localparam int K_W        = 11;
	localparam int COST_OUT_W = 52;
	localparam int APB_AW     = 2;
	localparam int APB_DW     = 32;

	// Register map (byte addresses).
	localparam logic [APB_AW-1:0] REG_NUM_GROUPS = 2'd0;
	localparam logic [K_W-1:0]    K_RESET        = 11'd1;

	// Controller states.
	typedef enum logic [4:0] {
		ST_LOAD,
		ST_CHECK,
		ST_ROW1_RD,
		ST_ROW1_DIFF,
		ST_ROW1_MUL,
		ST_ROW1_WR,
		ST_ROW_CHECK,
		ST_ROW_START,
		ST_POP,
		ST_SPAN_SETUP,
		ST_MID_RD,
		ST_MID_LAT,
		ST_CAND_RD,
		ST_CAND_DIFF,
		ST_CAND_MUL,
		ST_CAND_CMP,
		ST_SPAN_END,
		ST_SP_CHECK,
		ST_ROW_NEXT,
		ST_RES_RD,
		ST_FINISH
	} msp_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_en;
		logic init_calc;
		logic row1_rd;
		logic row1_diff;
		logic mul;
		logic row1_wr;
		logic row_start;
		logic pop;
		logic span_setup;
		logic mid_rd;
		logic mid_lat;
		logic cand_diff;
		logic cand_cmp;
		logic span_end;
		logic row_next;
		logic res_rd;
		logic finish;
	} msp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic infeasible;
		logic i_last;
		logic grp_done;
		logic cand_more;
		logic sp_zero;
		logic out_free;
	} msp_status_t;

endpackage

>>> rtl/core/msp_in_if.sv
interface msp_in_if #(
	parameter int VALUE_BITS = 16
) ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] element_value;
	logic                  last_element;

	modport source(output valid, element_value, last_element, input ready);
	modport sink(input valid, element_value, last_element, output ready);
endinterface

>>> rtl/core/msp_out_if.sv
interface msp_out_if ();
	logic        valid;
	logic        ready;
	logic [51:0] min_cost;
	logic        infeasible;
	logic        too_many;

	modport source(output valid, min_cost, infeasible, too_many, input ready);
	modport sink(input valid, min_cost, infeasible, too_many, output ready);
endinterface

>>> rtl/core/min_square_sum_partition_dp.sv
// Channel  Dir  Fields                                  Handshake
// in_ch    in   element_value, last_element             valid/ready
// out_ch   out  min_cost, infeasible, too_many          valid/ready
// apb      in   num_groups at byte address 0            psel/penable, pready high
//
// Loading accepts one element per cycle; an element with last_element set starts the solve.
// Row one takes each position through read, difference, squaring and write; each later row
// works span by span, every candidate split taking read, difference, squaring and compare
// in turn, as the squaring multiplier is shared and the prefix-sum memory has one read port.
// Reset clears the counters and the controller; the memories need no clearing.
// The input is not taken during the solve; a waiting result does not block loading.
module min_square_sum_partition_dp
	import msp_pkg::*;
#(
	parameter int MAX_N      = MAX_N_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	msp_in_if.sink            in_ch,
	msp_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	msp_cmd_t       cmd;
	msp_status_t    status;
	logic [K_W-1:0] num_groups_q;
	logic           in_accept;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_groups_q <= K_RESET;
		end else if (psel && penable && pwrite && (paddr == REG_NUM_GROUPS)) begin
			num_groups_q <= pwdata[K_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_NUM_GROUPS) ? APB_DW'(num_groups_q) : '0;

	assign in_ch.ready = cmd.load_en;
	assign in_accept   = in_ch.valid && cmd.load_en;

	msp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_last   (in_ch.last_element),
		.status    (status),
		.cmd       (cmd)
	);

	msp_datapath #(
		.MAX_N      (MAX_N),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_accept      (in_accept),
		.in_value       (in_ch.element_value),
		.num_groups     (num_groups_q),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_cost       (out_ch.min_cost),
		.out_infeasible (out_ch.infeasible),
		.out_too_many   (out_ch.too_many)
	);

endmodule

>>> rtl/core/msp_ctrl.sv
module msp_ctrl
	import msp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_accept,
	input  logic        in_last,
	input  msp_status_t status,
	output msp_cmd_t    cmd
);

	msp_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_LOAD: begin
				cmd.load_en = 1'b1;
				if (in_accept && in_last) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.init_calc = 1'b1;
				state_d = status.infeasible ? ST_FINISH : ST_ROW1_RD;
			end
			ST_ROW1_RD: begin
				cmd.row1_rd = 1'b1;
				state_d = ST_ROW1_DIFF;
			end
			ST_ROW1_DIFF: begin
				cmd.row1_diff = 1'b1;
				state_d = ST_ROW1_MUL;
			end
			ST_ROW1_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ROW1_WR;
			end
			ST_ROW1_WR: begin
				cmd.row1_wr = 1'b1;
				state_d = status.i_last ? ST_ROW_CHECK : ST_ROW1_RD;
			end
			ST_ROW_CHECK: begin
				state_d = status.grp_done ? ST_RES_RD : ST_ROW_START;
			end
			ST_ROW_START: begin
				cmd.row_start = 1'b1;
				state_d = ST_POP;
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_SPAN_SETUP;
			end
			ST_SPAN_SETUP: begin
				cmd.span_setup = 1'b1;
				state_d = ST_MID_RD;
			end
			ST_MID_RD: begin
				cmd.mid_rd = 1'b1;
				state_d = ST_MID_LAT;
			end
			ST_MID_LAT: begin
				cmd.mid_lat = 1'b1;
				state_d = ST_CAND_RD;
			end
			ST_CAND_RD: begin
				state_d = status.cand_more ? ST_CAND_DIFF : ST_SPAN_END;
			end
			ST_CAND_DIFF: begin
				cmd.cand_diff = 1'b1;
				state_d = ST_CAND_MUL;
			end
			ST_CAND_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CAND_CMP;
			end
			ST_CAND_CMP: begin
				cmd.cand_cmp = 1'b1;
				state_d = ST_CAND_RD;
			end
			ST_SPAN_END: begin
				cmd.span_end = 1'b1;
				state_d = ST_SP_CHECK;
			end
			ST_SP_CHECK: begin
				state_d = status.sp_zero ? ST_ROW_NEXT : ST_POP;
			end
			ST_ROW_NEXT: begin
				cmd.row_next = 1'b1;
				state_d = ST_ROW_CHECK;
			end
			ST_RES_RD: begin
				cmd.res_rd = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.res_rd = 1'b1;
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

>>> rtl/core/msp_datapath.sv
module msp_datapath
	import msp_pkg::*;
#(
	parameter int MAX_N      = MAX_N_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  msp_cmd_t              cmd,
	output msp_status_t           status,
	input  logic                  in_accept,
	input  logic [VALUE_BITS-1:0] in_value,
	input  logic [K_W-1:0]        num_groups,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COST_OUT_W-1:0] out_cost,
	output logic                  out_infeasible,
	output logic                  out_too_many
);

	localparam int IW   = $clog2(MAX_N + 2);
	localparam int PSW  = VALUE_BITS + $clog2(MAX_N + 1);
	localparam int SQW  = 2 * PSW;
	localparam int CW   = SQW + 1;
	localparam int SD   = $clog2(MAX_N) + 2;
	localparam int SPW  = $clog2(SD + 1);
	localparam int CMPW = (IW > K_W) ? IW : K_W;
	localparam int AW   = $clog2(MAX_N + 1);

	// Prefix sums and the two row banks.
	logic [PSW-1:0] ps_mem [MAX_N+1];
	logic [CW-1:0]  bank_a [MAX_N+1];
	logic [CW-1:0]  bank_b [MAX_N+1];

	// Range stack.
	logic [IW-1:0] stk_lo [SD];
	logic [IW-1:0] stk_hi [SD];
	logic [IW-1:0] stk_olo [SD];
	logic [IW-1:0] stk_ohi [SD];
	logic [SPW-1:0] sp_q;

	logic [IW-1:0]  cnt_q, i_q, grp_q, lo_q, hi_q, olo_q, ohi_q, mid_q, jmax_q, j_q, bestj_q;
	logic [PSW-1:0] sum_q, psmid_q, ps_rd_q;
	logic           ps_zero_q, ovf_q, inf_q, rowsel_q, found_q;
	logic [PSW-1:0] diff_q;
	logic [SQW-1:0] sq_q;
	logic [CW-1:0]  prevv_q, best_q, a_rd_q, b_rd_q;
	logic           out_valid_q, out_inf_q, out_tm_q;
	logic [COST_OUT_W-1:0] out_cost_q;

	logic [IW-1:0]  ps_addr, row_addr, mid_c, jmax_c;
	logic [PSW-1:0] ps_val;
	logic [CW-1:0]  row_val, cand_v;
	logic           row_we, wr_bank;
	logic [IW-1:0]  wr_addr;
	logic [CW-1:0]  wr_data;
	logic [CMPW-1:0] k_ext, n_ext, g_ext;

	assign k_ext = CMPW'(num_groups);
	assign n_ext = CMPW'(cnt_q);
	assign g_ext = CMPW'(grp_q);

	// Prefix sum memory: written on load, read at one address.
	always_comb begin
		ps_addr = j_q;
		if (cmd.row1_rd) ps_addr = i_q;
		else if (cmd.mid_rd) ps_addr = mid_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en && in_accept && (cnt_q < IW'(MAX_N))) begin
			ps_mem[AW'(cnt_q + 1'b1)] <= sum_q + PSW'(in_value);
		end
		ps_rd_q   <= ps_mem[AW'(ps_addr)];
		ps_zero_q <= (ps_addr == '0);
	end

	// Entry zero is never written and reads as zero.
	assign ps_val = ps_zero_q ? '0 : ps_rd_q;

	// Row banks: one write, one read each cycle.
	assign row_addr = cmd.res_rd ? cnt_q : j_q;
	assign row_we   = cmd.row1_wr || cmd.span_end;
	assign wr_bank  = cmd.row1_wr ? rowsel_q : !rowsel_q;
	assign wr_addr  = cmd.row1_wr ? i_q : mid_q;
	assign wr_data  = cmd.row1_wr ? CW'(sq_q) : best_q;

	always_ff @(posedge clk) begin
		if (row_we && !wr_bank) bank_a[AW'(wr_addr)] <= wr_data;
		if (row_we && wr_bank) bank_b[AW'(wr_addr)] <= wr_data;
		a_rd_q <= bank_a[AW'(row_addr)];
		b_rd_q <= bank_b[AW'(row_addr)];
	end

	assign row_val = rowsel_q ? b_rd_q : a_rd_q;

	// Span midpoint and upper split bound.
	assign mid_c  = lo_q + ((hi_q - lo_q) >> 1);
	assign jmax_c = ((mid_c - 1'b1) < ohi_q) ? (mid_c - 1'b1) : ohi_q;
	assign cand_v = prevv_q + CW'(sq_q);

	// Load counters, flags, bank select and stack pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			sum_q    <= '0;
			ovf_q    <= 1'b0;
			sp_q     <= '0;
			rowsel_q <= 1'b0;
			inf_q    <= 1'b0;
		end else begin
			if (cmd.load_en && in_accept) begin
				if (cnt_q < IW'(MAX_N)) begin
					cnt_q <= cnt_q + 1'b1;
					sum_q <= sum_q + PSW'(in_value);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.init_calc) begin
				inf_q    <= (k_ext == '0) || (k_ext > n_ext);
				rowsel_q <= 1'b0;
			end
			if (cmd.row_next) rowsel_q <= !rowsel_q;
			if (cmd.row_start) sp_q <= SPW'(1);
			if (cmd.pop) sp_q <= sp_q - 1'b1;
			if (cmd.span_end) begin
				if ((mid_q < hi_q) && (mid_q > lo_q) && (sp_q < SPW'(SD - 1))) begin
					sp_q <= sp_q + SPW'(2);
				end else if (((mid_q < hi_q) || (mid_q > lo_q)) && (sp_q < SPW'(SD))) begin
					sp_q <= sp_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				cnt_q <= '0;
				sum_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// Stack pushes: right half below, left half on top.
	always_ff @(posedge clk) begin
		if (cmd.row_start) begin
			stk_lo[0]  <= grp_q;
			stk_hi[0]  <= cnt_q;
			stk_olo[0] <= grp_q - 1'b1;
			stk_ohi[0] <= cnt_q - 1'b1;
		end
		if (cmd.span_end) begin
			if ((mid_q < hi_q) && (sp_q < SPW'(SD))) begin
				stk_lo[sp_q]  <= mid_q + 1'b1;
				stk_hi[sp_q]  <= hi_q;
				stk_olo[sp_q] <= bestj_q;
				stk_ohi[sp_q] <= ohi_q;
				if ((mid_q > lo_q) && (sp_q < SPW'(SD - 1))) begin
					stk_lo[sp_q + 1'b1]  <= lo_q;
					stk_hi[sp_q + 1'b1]  <= mid_q - 1'b1;
					stk_olo[sp_q + 1'b1] <= olo_q;
					stk_ohi[sp_q + 1'b1] <= bestj_q;
				end
			end else if ((mid_q > lo_q) && (sp_q < SPW'(SD))) begin
				stk_lo[sp_q]  <= lo_q;
				stk_hi[sp_q]  <= mid_q - 1'b1;
				stk_olo[sp_q] <= olo_q;
				stk_ohi[sp_q] <= bestj_q;
			end
		end
	end

	// Row, span and candidate working registers.
	always_ff @(posedge clk) begin
		if (cmd.init_calc) begin
			i_q   <= IW'(1);
			grp_q <= IW'(2);
		end
		if (cmd.row1_wr) i_q <= i_q + 1'b1;
		if (cmd.row_next) grp_q <= grp_q + 1'b1;
		if (cmd.pop) begin
			lo_q  <= stk_lo[sp_q - 1'b1];
			hi_q  <= stk_hi[sp_q - 1'b1];
			olo_q <= stk_olo[sp_q - 1'b1];
			ohi_q <= stk_ohi[sp_q - 1'b1];
		end
		if (cmd.span_setup) begin
			mid_q   <= mid_c;
			jmax_q  <= jmax_c;
			j_q     <= olo_q;
			bestj_q <= olo_q;
			best_q  <= '1;
			found_q <= 1'b0;
		end
		if (cmd.mid_lat) psmid_q <= ps_val;
		if (cmd.row1_diff) diff_q <= ps_val;
		if (cmd.cand_diff) begin
			diff_q  <= psmid_q - ps_val;
			prevv_q <= row_val;
		end
		if (cmd.mul) sq_q <= diff_q * diff_q;
		if (cmd.cand_cmp) begin
			if (!found_q || (cand_v < best_q)) begin
				best_q  <= cand_v;
				bestj_q <= j_q;
			end
			found_q <= 1'b1;
			j_q     <= j_q + 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_cost_q <= inf_q ? '0 : COST_OUT_W'(row_val);
			out_inf_q  <= inf_q;
			out_tm_q   <= ovf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_cost       = out_cost_q;
	assign out_infeasible = out_inf_q;
	assign out_too_many   = out_tm_q;

	assign status.infeasible = (k_ext == '0) || (k_ext > n_ext);
	assign status.i_last     = (i_q == cnt_q);
	assign status.grp_done   = (g_ext > k_ext);
	assign status.cand_more  = (j_q <= jmax_q);
	assign status.sp_zero    = (sp_q == '0);
	assign status.out_free   = !out_valid_q || out_ready;

	// The range stack never grows past its depth.
	assert property (@(posedge clk) disable iff (!arst_n) sp_q <= SPW'(SD))
		else $error("range stack overflow");

	// The element count stays within capacity.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= IW'(MAX_N))
		else $error("element count beyond capacity");

	// Dropped elements are only flagged with a full set.
	assert property (@(posedge clk) disable iff (!arst_n) ovf_q |-> (cnt_q == IW'(MAX_N)))
		else $error("overflow flag without full set");

	// A candidate split point always lies left of the midpoint.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.cand_cmp |-> (j_q < mid_q))
		else $error("split point beyond midpoint");

endmodule
